// ===== rtl/core/subcentroid_alpha_estimator_unit_defines.svh =====
// Assertion macros for the subcentroid alpha estimator.
// Both expect clk and rst in the scope where they are used.
`ifndef SUBCENTROID_ALPHA_ESTIMATOR_UNIT_DEFINES_SVH
`define SUBCENTROID_ALPHA_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SAE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SAE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sae_pkg.sv =====
package sae_pkg;

  localparam int MAX_DIMS   = 128;
  localparam int MAX_DIRS   = 16;
  localparam int COUNT_BITS = 24;

  localparam int DIM_W   = $clog2(MAX_DIMS);
  localparam int DIR_W   = $clog2(MAX_DIRS);
  localparam int COMP_W  = 16;
  localparam int RES_W   = COMP_W + 1;
  localparam int NORM_W  = 40;
  localparam int ACC_W   = 40;
  localparam int N_W     = 38;
  localparam int SQ_W    = 2 * N_W;
  localparam int MUL_A_W = SQ_W;
  localparam int MUL_B_W = NORM_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ALPHA_W = 32;
  localparam int FRAC_W  = 16;
  localparam int GSUM_W  = 64;
  localparam int DIV_NUM_W = GSUM_W + FRAC_W;
  localparam int DIV_DEN_W = GSUM_W;
  localparam int ASUM_W  = 48;
  localparam int TOT_W   = ASUM_W + DIR_W;

  typedef enum logic [2:0] {
    OP_CENTROID  = 3'd0,
    OP_DIRECTION = 3'd1,
    OP_NORM      = 3'd2,
    OP_POINT     = 3'd3,
    OP_FINISH    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_DIMS = 2'd0,
    REG_SUBS = 2'd1,
    REG_MODE = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RES, S_SWEEP, S_DRAIN, S_SEL, S_SQ, S_MA, S_MB, S_SELEND,
    S_ALPHA, S_UPD, S_FSUM, S_FAVG, S_FK, S_FDIV, S_EMIT
  } state_t;

  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic [DIM_W-1:0]        dim;
    logic signed [RES_W-1:0] res;
  } link_t;

  typedef struct packed {
    logic               dir_we;
    logic               norm_we;
    logic [DIR_W-1:0]   wr_sub;
    logic [DIM_W-1:0]   wr_dim;
    logic [COMP_W-1:0]  wr_comp;
    logic [NORM_W-1:0]  norm_val;
    logic               upd_en;
    logic [DIR_W-1:0]   upd_sub;
    logic [ALPHA_W-1:0] upd_alpha;
    logic               clr_group;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [NORM_W-1:0]       norm;
    logic [ASUM_W-1:0]       asum;
    logic [COUNT_BITS-1:0]   hit;
  } cell_stat_t;

endpackage

// ===== rtl/core/sae_if.sv =====
interface sae_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic [sae_pkg::DIR_W-1:0]    sub_index;
  logic [sae_pkg::DIM_W-1:0]    dim_index;
  logic signed [sae_pkg::COMP_W-1:0] component;
  logic [sae_pkg::NORM_W-1:0]   norm_value;
  modport source (output valid, opcode, sub_index, dim_index, component, norm_value,
                  input ready);
  modport sink (input valid, opcode, sub_index, dim_index, component, norm_value,
                output ready);
endinterface

interface sae_out_if;
  logic                         valid;
  logic                         ready;
  logic [sae_pkg::DIR_W-1:0]    out_index;
  logic [sae_pkg::ALPHA_W-1:0]  alpha;
  logic                         last;
  logic                         empty_group;
  modport source (output valid, out_index, alpha, last, empty_group, input ready);
  modport sink (input valid, out_index, alpha, last, empty_group, output ready);
endinterface

interface sae_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/subcentroid_alpha_estimator_unit.sv =====
// Subcentroid alpha estimator. Load a centroid, up to 16 direction vectors
// and their squared norms, then stream points one component per beat. The
// completing component of a point starts a sweep of the residual through a
// row of 16 cells, one per direction, each with its own direction memory
// and multiply-accumulate; the residual steps one cell per cycle. The best
// direction is then chosen one direction at a time with a shared shift-add
// multiplier, and its alpha comes from a shared divider.
// Steps per input beat: centroid, direction and norm beats and unused
// opcodes are taken in idle; a point component also writes its residual.
// The completing component then adds the sweep and the drain, then per
// direction a skip when its score is zero, else a square (first nonzero)
// or a square and two products (compared), then closing the choice, the
// alpha division when the chosen norm is nonzero, and updating the sums.
// A finish emits K beats plus waits on the output; it adds the group
// ratio division (mode 0, nonzero norm sum) or a sum over the K directions,
// the average division and a division per direction with hits (mode 1).
// Alpha is unsigned Q16.16, truncated and saturating. One item is in work
// at a time; the input is not taken while results are pending.
`include "subcentroid_alpha_estimator_unit_defines.svh"

module subcentroid_alpha_estimator_unit (
  input logic       clk,
  input logic       rst,
  sae_cfg_if.sink   cfg,
  sae_in_if.sink    item,
  sae_out_if.source result
);
  import sae_pkg::*;

  // Configuration
  logic [7:0] dims_cfg;
  logic [4:0] subs_cfg;
  logic       mode_cfg;
  logic [7:0] eff_dims;
  logic [4:0] eff_dirs;
  logic [DIM_W-1:0] last_dim;
  logic [DIR_W-1:0] last_dir;

  state_t state, state_next;

  logic [DIM_W-1:0]  pt_dim;
  logic [COMP_W-1:0] pt_comp;
  logic [DIM_W-1:0]  sweep_d;
  logic              inj_valid, inj_first, inj_last;
  logic [DIM_W-1:0]  inj_dim;

  logic [COMP_W-1:0] cent_rdata;
  logic [RES_W-1:0]  res_wdata, res_rdata;

  link_t      links [MAX_DIRS+1];
  cell_stat_t stats [MAX_DIRS];
  cell_ctl_t  ctl;
  cell_stat_t cur;

  logic [DIR_W-1:0]  sel_k, best_k;
  logic [N_W-1:0]    best_n, n_cur;
  logic [NORM_W-1:0] best_d, nd_cur;
  logic [SQ_W-1:0]   best_sq, sq_reg;
  logic              best_zero, zero_cur;
  logic [PROD_W-1:0] prod_a;
  logic [ALPHA_W-1:0] alpha_pt;

  logic [GSUM_W-1:0]     gnum, gden;
  logic [COUNT_BITS-1:0] pcount;
  logic [TOT_W-1:0]      total;
  logic [ALPHA_W-1:0]    avg;
  logic                  group_empty;
  logic [GSUM_W:0]       gnum_sum, gden_sum;

  logic [DIR_W-1:0]   res_index;
  logic [ALPHA_W-1:0] res_alpha;
  logic               res_last, res_empty;

  logic                 mul_start, mul_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_prod;
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [ALPHA_W-1:0]   div_quo;

  logic in_beat, out_beat, sel_last;
  logic sq_take, mb_take;

  assign eff_dims = (dims_cfg == '0) ? 8'd1 :
                    (dims_cfg > 8'(MAX_DIMS)) ? 8'(MAX_DIMS) : dims_cfg;
  assign eff_dirs = (subs_cfg == '0) ? 5'd1 :
                    (subs_cfg > 5'(MAX_DIRS)) ? 5'(MAX_DIRS) : subs_cfg;
  assign last_dim = DIM_W'(eff_dims - 8'd1);
  assign last_dir = DIR_W'(eff_dirs - 5'd1);

  assign cfg.ready = 1'b1;
  assign in_beat   = item.valid && item.ready;
  assign out_beat  = result.valid && result.ready;
  assign sel_last  = (sel_k == last_dir);
  assign group_empty = (pcount == '0);

  // Centroid and residual memories
  sae_ram #(.WIDTH(COMP_W), .DEPTH(MAX_DIMS)) u_cent (
    .clk   (clk),
    .we    (in_beat && (item.opcode == OP_CENTROID)),
    .waddr (item.dim_index),
    .wdata (item.component),
    .raddr (item.dim_index),
    .rdata (cent_rdata)
  );

  assign res_wdata = {pt_comp[COMP_W-1], pt_comp} - {cent_rdata[COMP_W-1], cent_rdata};

  sae_ram #(.WIDTH(RES_W), .DEPTH(MAX_DIMS)) u_res (
    .clk   (clk),
    .we    (state == S_RES),
    .waddr (pt_dim),
    .wdata (res_wdata),
    .raddr (sweep_d),
    .rdata (res_rdata)
  );

  // Row of direction cells
  assign links[0].valid = inj_valid;
  assign links[0].first = inj_first;
  assign links[0].last  = inj_last;
  assign links[0].dim   = inj_dim;
  assign links[0].res   = res_rdata;

  for (genvar i = 0; i < MAX_DIRS; i++) begin : g_cell
    sae_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (DIR_W'(i)),
      .ctl      (ctl),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .stat     (stats[i])
    );
  end

  assign cur      = stats[sel_k];
  assign n_cur    = (!cur.acc[ACC_W-1]) ? cur.acc[N_W-1:0] : '0;
  assign nd_cur   = cur.norm;
  assign zero_cur = (n_cur == '0) || (nd_cur == '0);
  assign sq_take  = (sel_k == '0) || best_zero;
  assign mb_take  = (prod_a >= mul_prod);

  sae_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sae_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Broadcast control to the cells
  always_comb begin
    ctl.dir_we    = in_beat && (item.opcode == OP_DIRECTION);
    ctl.norm_we   = in_beat && (item.opcode == OP_NORM);
    ctl.wr_sub    = item.sub_index;
    ctl.wr_dim    = item.dim_index;
    ctl.wr_comp   = item.component;
    ctl.norm_val  = item.norm_value;
    ctl.upd_en    = (state == S_UPD);
    ctl.upd_sub   = best_k;
    ctl.upd_alpha = alpha_pt;
    ctl.clr_group = out_beat && sel_last;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit launches
  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.opcode)
            OP_POINT:  state_next = S_RES;
            OP_FINISH: begin
              if (group_empty) begin
                state_next = S_FK;
              end else if (mode_cfg) begin
                state_next = S_FSUM;
              end else if (gden == '0) begin
                state_next = S_FK;
              end else begin
                state_next = S_FAVG;
              end
            end
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RES:   state_next = (pt_dim == last_dim) ? S_SWEEP : S_IDLE;
      S_SWEEP: if (sweep_d == last_dim) state_next = S_DRAIN;
      S_DRAIN: if (links[MAX_DIRS].valid && links[MAX_DIRS].last) state_next = S_SEL;
      S_SEL: begin
        if (!zero_cur) begin
          state_next = S_SQ;
        end else begin
          state_next = sel_last ? S_SELEND : S_SEL;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          if (!sq_take) begin
            state_next = S_MA;
          end else begin
            state_next = sel_last ? S_SELEND : S_SEL;
          end
        end
      end
      S_MA:     if (mul_done) state_next = S_MB;
      S_MB:     if (mul_done) state_next = sel_last ? S_SELEND : S_SEL;
      S_SELEND: state_next = (best_d == '0) ? S_UPD : S_ALPHA;
      S_ALPHA:  if (div_done) state_next = S_UPD;
      S_UPD:    state_next = S_IDLE;
      S_FSUM:   if (sel_last) state_next = S_FAVG;
      S_FAVG:   if (div_done) state_next = S_FK;
      S_FK: begin
        if (!group_empty && mode_cfg && (cur.hit != '0)) begin
          state_next = S_FDIV;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FDIV:   if (div_done) state_next = S_EMIT;
      S_EMIT:   if (result.ready) state_next = sel_last ? S_IDLE : S_FK;
      default:  state_next = S_IDLE;
    endcase

    mul_start = (state_next != state) &&
                ((state_next == S_SQ) || (state_next == S_MA) || (state_next == S_MB));
    div_start = (state_next != state) &&
                ((state_next == S_ALPHA) || (state_next == S_FAVG) || (state_next == S_FDIV));

    case (state_next)
      S_MA: begin
        mul_a = mul_prod[MUL_A_W-1:0];
        mul_b = best_d;
      end
      S_MB: begin
        mul_a = best_sq;
        mul_b = nd_cur;
      end
      default: begin
        mul_a = MUL_A_W'(n_cur);
        mul_b = MUL_B_W'(n_cur);
      end
    endcase

    case (state_next)
      S_ALPHA: begin
        div_num = DIV_NUM_W'({best_n, {FRAC_W{1'b0}}});
        div_den = DIV_DEN_W'(best_d);
      end
      S_FAVG: begin
        if (mode_cfg) begin
          // Launch from the last summing cycle: fold in its direction
          div_num = DIV_NUM_W'(total + TOT_W'(cur.asum));
          div_den = DIV_DEN_W'(pcount);
        end else begin
          div_num = {gnum, {FRAC_W{1'b0}}};
          div_den = gden;
        end
      end
      default: begin
        div_num = DIV_NUM_W'(cur.asum);
        div_den = DIV_DEN_W'(cur.hit);
      end
    endcase
  end

  assign gnum_sum = {1'b0, gnum} + (GSUM_W + 1)'(best_n);
  assign gden_sum = {1'b0, gden} + (GSUM_W + 1)'(best_d);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_cfg  <= 8'(MAX_DIMS);
      subs_cfg  <= 5'(MAX_DIRS);
      mode_cfg  <= 1'b0;
      inj_valid <= 1'b0;
      gnum      <= '0;
      gden      <= '0;
      pcount    <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_DIMS: dims_cfg <= cfg.data;
          REG_SUBS: subs_cfg <= cfg.data[4:0];
          REG_MODE: mode_cfg <= cfg.data[0];
          default:  ;
        endcase
      end

      inj_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            pt_dim  <= item.dim_index;
            pt_comp <= item.component;
            sel_k   <= '0;
            total   <= '0;
            avg     <= '0;
          end
        end
        S_RES: begin
          sweep_d <= '0;
        end
        // Feed the residual into the row
        S_SWEEP: begin
          inj_valid <= 1'b1;
          inj_first <= (sweep_d == '0);
          inj_last  <= (sweep_d == last_dim);
          inj_dim   <= sweep_d;
          sweep_d   <= sweep_d + 1'b1;
        end
        S_DRAIN: begin
          sel_k     <= '0;
          best_zero <= 1'b1;
        end
        // Score one direction; ties go to the higher index
        S_SEL: begin
          if (zero_cur) begin
            if (sq_take) begin
              best_k    <= sel_k;
              best_n    <= n_cur;
              best_d    <= nd_cur;
              best_zero <= 1'b1;
            end
            if (!sel_last) sel_k <= sel_k + 1'b1;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            sq_reg <= mul_prod[SQ_W-1:0];
            if (sq_take) begin
              best_k    <= sel_k;
              best_n    <= n_cur;
              best_d    <= nd_cur;
              best_sq   <= mul_prod[SQ_W-1:0];
              best_zero <= 1'b0;
              if (!sel_last) sel_k <= sel_k + 1'b1;
            end
          end
        end
        S_MA: begin
          if (mul_done) prod_a <= mul_prod;
        end
        S_MB: begin
          if (mul_done) begin
            if (mb_take) begin
              best_k  <= sel_k;
              best_n  <= n_cur;
              best_d  <= nd_cur;
              best_sq <= sq_reg;
            end
            if (!sel_last) sel_k <= sel_k + 1'b1;
          end
        end
        S_SELEND: begin
          alpha_pt <= '0;
        end
        S_ALPHA: begin
          if (div_done) alpha_pt <= div_quo;
        end
        // Add the point to the group sums
        S_UPD: begin
          gnum <= gnum_sum[GSUM_W] ? '1 : gnum_sum[GSUM_W-1:0];
          gden <= gden_sum[GSUM_W] ? '1 : gden_sum[GSUM_W-1:0];
          if (pcount != '1) pcount <= pcount + 1'b1;
        end
        S_FSUM: begin
          total <= total + TOT_W'(cur.asum);
          sel_k <= sel_last ? '0 : sel_k + 1'b1;
        end
        S_FAVG: begin
          if (div_done) avg <= div_quo;
        end
        S_FK: begin
          res_index <= sel_k;
          res_alpha <= group_empty ? '0 : avg;
          res_last  <= sel_last;
          res_empty <= group_empty;
        end
        S_FDIV: begin
          if (div_done) res_alpha <= div_quo;
        end
        // Advance on each accepted beat; clear the group after the last
        S_EMIT: begin
          if (result.ready) begin
            if (sel_last) begin
              gnum   <= '0;
              gden   <= '0;
              pcount <= '0;
            end else begin
              sel_k <= sel_k + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid       = (state == S_EMIT);
  assign result.out_index   = res_index;
  assign result.alpha       = res_alpha;
  assign result.last        = res_last;
  assign result.empty_group = res_empty;

  `SAE_ASSERT_IMP(a_no_take_while_emit, result.valid, !item.ready, "input taken with result pending")
  `SAE_ASSERT_IMP(a_last_index, result.valid && result.last, result.out_index == last_dir, "last beat on wrong direction")
  `SAE_ASSERT_IMP(a_empty_zero, result.valid && result.empty_group, result.alpha == '0, "empty group with nonzero alpha")
  `SAE_ASSERT_NXT(a_gap_after_beat, out_beat, !result.valid, "result reloaded without gap")

endmodule

// ===== rtl/core/sae_ram.sv =====
module sae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sae_mul.sv =====
module sae_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sae_pkg::MUL_A_W-1:0] a,
  input  logic [sae_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [sae_pkg::PROD_W-1:0]  prod
);
  import sae_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic [PROD_W-1:0]  a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic [CNT_W-1:0]   cnt;
  logic               run;

  // Shift-add: one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sh <= PROD_W'(a);
        b_sh <= b;
        prod <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (b_sh[0]) begin
          prod <= prod + a_sh;
        end
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sae_div.sv =====
module sae_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sae_pkg::DIV_NUM_W-1:0] num,
  input  logic [sae_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [sae_pkg::ALPHA_W-1:0]   quo
);
  import sae_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] num_sh;
  logic [DIV_NUM_W-1:0] q;
  logic [CNT_W-1:0]     cnt;
  logic                 run;
  logic [DIV_DEN_W:0]   trial;

  assign trial = {rem, num_sh[DIV_NUM_W-1]};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= '0;
        den_r  <= den;
        num_sh <= num;
        q      <= '0;
        cnt    <= '0;
        run    <= 1'b1;
      end else if (run) begin
        num_sh <= num_sh << 1;
        if (trial >= {1'b0, den_r}) begin
          rem <= DIV_DEN_W'(trial - {1'b0, den_r});
          q   <= {q[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DEN_W-1:0];
          q   <= {q[DIV_NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate to the alpha width
  assign quo = (|q[DIV_NUM_W-1:ALPHA_W]) ? '1 : q[ALPHA_W-1:0];

endmodule

// ===== rtl/core/sae_cell.sv =====
module sae_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sae_pkg::DIR_W-1:0]  cell_idx,
  input  sae_pkg::cell_ctl_t         ctl,
  input  sae_pkg::link_t             link_in,
  output sae_pkg::link_t             link_out,
  output sae_pkg::cell_stat_t        stat
);
  import sae_pkg::*;

  localparam int PR_W = RES_W + COMP_W;

  logic [COMP_W-1:0]       dir_rdata;
  link_t                   stage;
  logic signed [PR_W-1:0]  prod;
  logic signed [ACC_W-1:0] acc;
  logic [NORM_W-1:0]       norm;
  logic [ASUM_W-1:0]       asum;
  logic [COUNT_BITS-1:0]   hit;
  logic [ASUM_W:0]         asum_sum;
  logic                    mine_upd;

  // Direction slice of this cell, read at the dimension riding the chain
  sae_ram #(.WIDTH(COMP_W), .DEPTH(MAX_DIMS)) u_dir (
    .clk   (clk),
    .we    (ctl.dir_we && (ctl.wr_sub == cell_idx)),
    .waddr (ctl.wr_dim),
    .wdata (ctl.wr_comp),
    .raddr (link_in.dim),
    .rdata (dir_rdata)
  );

  // Register the residual beat, aligned with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= link_in;
    end
  end

  assign prod = stage.res * $signed(dir_rdata);

  // Accumulate the projection; first element restarts it
  always_ff @(posedge clk) begin
    if (stage.valid) begin
      if (stage.first) begin
        acc <= {{(ACC_W-PR_W){prod[PR_W-1]}}, prod};
      end else begin
        acc <= acc + {{(ACC_W-PR_W){prod[PR_W-1]}}, prod};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.norm_we && (ctl.wr_sub == cell_idx)) begin
      norm <= ctl.norm_val;
    end
  end

  assign mine_upd = ctl.upd_en && (ctl.upd_sub == cell_idx);
  assign asum_sum = {1'b0, asum} + (ASUM_W + 1)'(ctl.upd_alpha);

  // Group sums of this direction, saturating
  always_ff @(posedge clk) begin
    if (rst || ctl.clr_group) begin
      asum <= '0;
      hit  <= '0;
    end else if (mine_upd) begin
      asum <= asum_sum[ASUM_W] ? '1 : asum_sum[ASUM_W-1:0];
      if (hit != '1) begin
        hit <= hit + 1'b1;
      end
    end
  end

  assign link_out  = stage;
  assign stat.acc  = acc;
  assign stat.norm = norm;
  assign stat.asum = asum;
  assign stat.hit  = hit;

endmodule
